/* rtl/modular_exponentiation_bytewise_macros.svh */
// assertion macros used by the rtl
`ifndef MODULAR_EXPONENTIATION_BYTEWISE_MACROS_SVH
`define MODULAR_EXPONENTIATION_BYTEWISE_MACROS_SVH

// same-cycle implication
`define MEXP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MEXP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mexp_pkg.sv */
package mexp_pkg;

  // width of the length registers
  localparam int unsigned LEN_W = 6;

  // request commands
  localparam logic [1:0] CMD_LOAD_MOD = 2'd0;
  localparam logic [1:0] CMD_LOAD_BASE = 2'd1;
  localparam logic [1:0] CMD_LOAD_EXP = 2'd2;
  localparam logic [1:0] CMD_START = 2'd3;

  // register indexes
  localparam logic [1:0] REG_MOD_LEN = 2'd0;
  localparam logic [1:0] REG_BASE_LEN = 2'd1;
  localparam logic [1:0] REG_EXP_LEN = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COPY,
    ST_MM_BIT,
    ST_MM_DBL,
    ST_MM_ADD,
    ST_EXP,
    ST_EBIT,
    ST_SIG,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    OP_BRED,
    OP_SQR,
    OP_MUL
  } op_e;

  // controls from the sequencer to the serial datapath
  typedef struct packed {
    logic       m_shift;
    logic [7:0] m_byte;
    logic       pass_en;
    logic       pass_add;
    logic       pass_last;
    logic       r_clear;
    logic       r_one;
    logic       r_bred;
    logic       r_rot;
    logic       a_acc;
    logic       a_one;
    logic       a_bred;
    logic       b_save;
  } alu_ctrl_t;

endpackage

/* rtl/mexp_serial_alu.sv */
module mexp_serial_alu #(
  parameter int unsigned MAX_BYTES = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mexp_pkg::alu_ctrl_t    ctrl_i,
  output logic [7:0]             r_byte_o,
  output logic [8*MAX_BYTES-1:0] acc_o
);

  localparam int unsigned WB = 8 * (MAX_BYTES + 1);
  localparam int unsigned VB = 8 * MAX_BYTES;

  logic [WB-1:0] r_q, s_q, a_q, m_q;
  logic [VB-1:0] b_q;
  logic          c_q, bw_q;

  logic [7:0]    x_byte;
  logic [8:0]    t9, d9;
  logic [WB-1:0] r_sh, s_sh;

  // byte add of the addend (or of r itself when doubling), then trial subtract of the modulus
  assign x_byte = ctrl_i.pass_add ? a_q[7:0] : r_q[7:0];
  assign t9 = {1'b0, r_q[7:0]} + {1'b0, x_byte} + {8'd0, c_q};
  assign d9 = {1'b0, t9[7:0]} - {1'b0, m_q[7:0]} - {8'd0, bw_q};
  assign r_sh = {t9[7:0], r_q[WB-1:8]};
  assign s_sh = {d9[7:0], s_q[WB-1:8]};

  // carry and borrow of the running pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q  <= 1'b0;
      bw_q <= 1'b0;
    end else if (ctrl_i.pass_en) begin
      c_q  <= ctrl_i.pass_last ? 1'b0 : t9[8];
      bw_q <= ctrl_i.pass_last ? 1'b0 : d9[8];
    end
  end

  // byte shift lines
  always_ff @(posedge clk_i) begin
    if (ctrl_i.pass_en) begin
      r_q <= (ctrl_i.pass_last && !d9[8]) ? s_sh : r_sh;
      s_q <= s_sh;
      m_q <= {m_q[7:0], m_q[WB-1:8]};
      if (ctrl_i.pass_add) begin
        a_q <= {a_q[7:0], a_q[WB-1:8]};
      end
    end else begin
      if (ctrl_i.r_clear) begin
        r_q <= '0;
      end else if (ctrl_i.r_one) begin
        r_q <= WB'(1);
      end else if (ctrl_i.r_bred) begin
        r_q <= {8'd0, b_q};
      end else if (ctrl_i.r_rot) begin
        r_q <= {r_q[7:0], r_q[WB-1:8]};
      end
      if (ctrl_i.a_acc) begin
        a_q <= {8'd0, r_q[VB-1:0]};
      end else if (ctrl_i.a_one) begin
        a_q <= WB'(1);
      end else if (ctrl_i.a_bred) begin
        a_q <= {8'd0, b_q};
      end
      if (ctrl_i.m_shift) begin
        m_q <= {ctrl_i.m_byte, m_q[WB-1:8]};
      end
    end
    if (ctrl_i.b_save) begin
      b_q <= r_q[VB-1:0];
    end
  end

  assign r_byte_o = r_q[7:0];
  assign acc_o    = r_q[VB-1:0];

endmodule

/* rtl/modular_exponentiation_bytewise.sv */
// channel   | dir | payload
// s_axis    | in  | tdata: digit_index, digit_value; tuser: cmd
// m_axis    | out | tdata: result_index, result_byte, result_length; tlast: last
// apb       | in  | length registers at 0x0, 0x4, 0x8
// a load request is written straight into its operand store; a start first copies the operands
// each product bit is one step state plus one or two byte-serial passes over MAX_BYTES+1 bytes
// base reduction runs 8*base_length bits, each square or multiply 8*modulus_length bits
// each exponent bit passes ST_EXP and ST_EBIT; squares begin after the first set bit, later set bits
// add a multiply; a length scan over the result bytes, then one result byte per accepted cycle
// no request is taken until the last byte; reset is asynchronous, active low, lengths at 32
`include "modular_exponentiation_bytewise_macros.svh"

module modular_exponentiation_bytewise #(
  parameter int unsigned MAX_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [4:0] digit_index, [12:5] digit_value
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // [4:0] result_index, [12:5] result_byte,
                                       // [18:13] result_length
  output logic        m_axis_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned VB   = 8 * MAX_BYTES;
  localparam int unsigned AW   = $clog2(MAX_BYTES);
  localparam int unsigned IDXW = $clog2(MAX_BYTES + 1);
  localparam int unsigned BITW = $clog2(8 * MAX_BYTES + 1);
  localparam int unsigned QIW  = $clog2(8 * MAX_BYTES);

  mexp_pkg::state_e state_q, state_d;
  mexp_pkg::op_e    op_q, op_d;
  mexp_pkg::alu_ctrl_t ctrl;

  logic [mexp_pkg::LEN_W-1:0] mod_len_q, base_len_q, exp_len_q;
  logic [IDXW-1:0] cnt_q, cnt_d, sig_q, sig_d, ln, lb, le;
  logic [BITW-1:0] bcnt_q, bcnt_d, ecnt_q, ecnt_d, eidx;
  logic            started_q, started_d, nz_q, nz_d;
  logic [VB-1:0]   q_q, q_d;
  logic [7:0]      mod_store [MAX_BYTES];
  logic [7:0]      base_store [MAX_BYTES];
  logic [7:0]      exp_store [MAX_BYTES];
  logic [7:0]      r_byte, byte_m, byte_b, e_byte;
  logic [VB-1:0]   acc;
  logic            in_acc, cfg_wr, q_bit, e_bit, start_go, cnt_end;
  logic [4:0]      in_idx;
  logic [7:0]      in_val;

  assign in_idx = s_axis_tdata_i[4:0];
  assign in_val = s_axis_tdata_i[12:5];
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign start_go = in_acc && (s_axis_tuser_i == mexp_pkg::CMD_START) && (ln != '0);

  // clamped lengths
  assign ln = (32'(mod_len_q) > MAX_BYTES) ? IDXW'(MAX_BYTES) : IDXW'(mod_len_q);
  assign lb = (32'(base_len_q) > MAX_BYTES) ? IDXW'(MAX_BYTES) : IDXW'(base_len_q);
  assign le = (32'(exp_len_q) > MAX_BYTES) ? IDXW'(MAX_BYTES) : IDXW'(exp_len_q);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      mexp_pkg::REG_MOD_LEN:  prdata = {26'd0, mod_len_q};
      mexp_pkg::REG_BASE_LEN: prdata = {26'd0, base_len_q};
      mexp_pkg::REG_EXP_LEN:  prdata = {26'd0, exp_len_q};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_len_q  <= mexp_pkg::LEN_W'(32);
      base_len_q <= mexp_pkg::LEN_W'(32);
      exp_len_q  <= mexp_pkg::LEN_W'(32);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        mexp_pkg::REG_MOD_LEN:  mod_len_q <= pwdata[mexp_pkg::LEN_W-1:0];
        mexp_pkg::REG_BASE_LEN: base_len_q <= pwdata[mexp_pkg::LEN_W-1:0];
        mexp_pkg::REG_EXP_LEN:  exp_len_q <= pwdata[mexp_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // operand stores
  always_ff @(posedge clk_i) begin
    if (in_acc && (32'(in_idx) < MAX_BYTES)) begin
      case (s_axis_tuser_i)
        mexp_pkg::CMD_LOAD_MOD:  mod_store[AW'(in_idx)] <= in_val;
        mexp_pkg::CMD_LOAD_BASE: base_store[AW'(in_idx)] <= in_val;
        mexp_pkg::CMD_LOAD_EXP:  exp_store[AW'(in_idx)] <= in_val;
        default: ;
      endcase
    end
  end

  // sweep reads and bit picks
  assign byte_m = (cnt_q < ln) ? mod_store[AW'(cnt_q)] : 8'd0;
  assign byte_b = (cnt_q < lb) ? base_store[AW'(cnt_q)] : 8'd0;
  assign eidx   = ecnt_q - 1'b1;
  assign e_byte = exp_store[AW'(eidx >> 3)];
  assign e_bit  = e_byte[eidx[2:0]];
  assign q_bit  = q_q[QIW'(bcnt_q - 1'b1)];
  assign cnt_end = (cnt_q == IDXW'(MAX_BYTES));

  mexp_serial_alu #(
    .MAX_BYTES(MAX_BYTES)
  ) u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .r_byte_o(r_byte),
    .acc_o   (acc)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    cnt_d     = cnt_q;
    sig_d     = sig_q;
    bcnt_d    = bcnt_q;
    ecnt_d    = ecnt_q;
    started_d = started_q;
    nz_d      = nz_q;
    q_d       = q_q;
    ctrl      = '0;
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    unique case (state_q)
      mexp_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (start_go) begin
          cnt_d     = '0;
          nz_d      = 1'b0;
          started_d = 1'b0;
          state_d   = mexp_pkg::ST_COPY;
        end
      end
      mexp_pkg::ST_COPY: begin
        ctrl.m_shift = 1'b1;
        ctrl.m_byte  = byte_m;
        nz_d = nz_q || (byte_m != 8'd0);
        if (!cnt_end) begin
          q_d = {byte_b, q_q[VB-1:8]};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_end) begin
          cnt_d  = '0;
          ecnt_d = BITW'({le, 3'b000});
          if (nz_q) begin
            op_d   = mexp_pkg::OP_BRED;
            bcnt_d = BITW'({lb, 3'b000});
            ctrl.a_one   = 1'b1;
            ctrl.r_clear = 1'b1;
            state_d = mexp_pkg::ST_MM_BIT;
          end else begin
            ctrl.r_one = 1'b1;
            state_d = mexp_pkg::ST_EXP;
          end
        end
      end
      mexp_pkg::ST_MM_BIT: begin
        cnt_d = '0;
        if (bcnt_q == '0) begin
          unique case (op_q)
            mexp_pkg::OP_BRED: begin
              ctrl.b_save = 1'b1;
              ctrl.r_one  = 1'b1;
              state_d = mexp_pkg::ST_EXP;
            end
            mexp_pkg::OP_SQR: state_d = mexp_pkg::ST_EBIT;
            default: begin
              ecnt_d  = ecnt_q - 1'b1;
              state_d = mexp_pkg::ST_EXP;
            end
          endcase
        end else begin
          state_d = mexp_pkg::ST_MM_DBL;
        end
      end
      mexp_pkg::ST_MM_DBL, mexp_pkg::ST_MM_ADD: begin
        ctrl.pass_en   = 1'b1;
        ctrl.pass_add  = (state_q == mexp_pkg::ST_MM_ADD);
        ctrl.pass_last = cnt_end;
        cnt_d = cnt_q + 1'b1;
        if (cnt_end) begin
          cnt_d = '0;
          if ((state_q == mexp_pkg::ST_MM_DBL) && q_bit) begin
            state_d = mexp_pkg::ST_MM_ADD;
          end else begin
            bcnt_d  = bcnt_q - 1'b1;
            state_d = mexp_pkg::ST_MM_BIT;
          end
        end
      end
      mexp_pkg::ST_EXP: begin
        if (ecnt_q == '0) begin
          cnt_d   = '0;
          sig_d   = '0;
          state_d = mexp_pkg::ST_SIG;
        end else if (started_q && nz_q) begin
          // square the accumulator
          op_d   = mexp_pkg::OP_SQR;
          bcnt_d = BITW'({ln, 3'b000});
          q_d    = acc;
          ctrl.a_acc   = 1'b1;
          ctrl.r_clear = 1'b1;
          state_d = mexp_pkg::ST_MM_BIT;
        end else begin
          state_d = mexp_pkg::ST_EBIT;
        end
      end
      mexp_pkg::ST_EBIT: begin
        ecnt_d  = ecnt_q - 1'b1;
        state_d = mexp_pkg::ST_EXP;
        if (e_bit) begin
          started_d = 1'b1;
          if (!nz_q) begin
            ctrl.r_clear = 1'b1;
          end else if (!started_q) begin
            ctrl.r_bred = 1'b1;
          end else begin
            // multiply by the reduced base
            ecnt_d = ecnt_q;
            op_d   = mexp_pkg::OP_MUL;
            bcnt_d = BITW'({ln, 3'b000});
            q_d    = acc;
            ctrl.a_bred  = 1'b1;
            ctrl.r_clear = 1'b1;
            state_d = mexp_pkg::ST_MM_BIT;
          end
        end
      end
      mexp_pkg::ST_SIG: begin
        ctrl.r_rot = 1'b1;
        if ((cnt_q < ln) && (r_byte != 8'd0)) begin
          sig_d = cnt_q + 1'b1;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_end) begin
          cnt_d   = '0;
          state_d = mexp_pkg::ST_OUT;
        end
      end
      mexp_pkg::ST_OUT: begin
        m_axis_tvalid_o = 1'b1;
        if (m_axis_tready_i) begin
          ctrl.r_rot = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (m_axis_tlast_o) begin
            state_d = mexp_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = mexp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mexp_pkg::ST_IDLE;
      op_q      <= mexp_pkg::OP_BRED;
      cnt_q     <= '0;
      sig_q     <= '0;
      bcnt_q    <= '0;
      ecnt_q    <= '0;
      started_q <= 1'b0;
      nz_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      cnt_q     <= cnt_d;
      sig_q     <= sig_d;
      bcnt_q    <= bcnt_d;
      ecnt_q    <= ecnt_d;
      started_q <= started_d;
      nz_q      <= nz_d;
    end
  end

  // multiplier bits
  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  // result request
  assign m_axis_tlast_o = (cnt_q == (ln - 1'b1));
  assign m_axis_tdata_o = {5'd0, 6'(sig_q), r_byte, 5'(cnt_q)};

  `MEXP_ASSERT_IMP(a_one_side, clk_i, rst_ni, s_axis_tready_o, !m_axis_tvalid_o, "both sides open")
  `MEXP_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start_go, !s_axis_tready_o, "start not taken")
  `MEXP_ASSERT_IMP(a_pass_cnt, clk_i, rst_ni, (state_q == mexp_pkg::ST_MM_DBL) || (state_q == mexp_pkg::ST_MM_ADD) || (state_q == mexp_pkg::ST_SIG), cnt_q <= IDXW'(MAX_BYTES), "pass count overrun")
  `MEXP_ASSERT_NXT(a_last_idle, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o, s_axis_tready_o, "no return to idle")

endmodule

/* sim/modular_exponentiation_bytewise_tb.sv */
`timescale 1ns / 100ps

module modular_exponentiation_bytewise_tb;

  localparam int unsigned NBYTES = 32;
  localparam int unsigned DRAIN_CYCLES = 3000;

  // one result byte as seen on the master side
  typedef struct {
    logic [4:0] index;
    logic [7:0] value;
    logic [5:0] length;
    logic       last;
  } res_byte_t;

  // one directed request, with an optional typed-in remainder
  typedef struct {
    logic [1:0] cmd;
    logic [4:0] index;
    logic [7:0] value;
    bit         typed;
    int         known;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;  // [4:0] digit_index, [12:5] digit_value
  logic [1:0]  s_axis_tuser_i = '0;  // [1:0] cmd
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;       // [4:0] result_index, [12:5] result_byte,
                                     // [18:13] result_length
  logic        m_axis_tlast_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  modular_exponentiation_bytewise dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // local copy of the block state
  logic [7:0] mod_digits [NBYTES];
  logic [7:0] base_digits [NBYTES];
  logic [7:0] exp_digits [NBYTES];
  logic [5:0] mod_len_q = 6'd32;
  logic [5:0] base_len_q = 6'd32;
  logic [5:0] exp_len_q = 6'd32;

  res_byte_t remainder_q[$];
  int  failures = 0;
  int  items_sent = 0;
  int  starts_sent = 0;
  int  bytes_seen = 0;
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  typed_pending = 0;
  int  typed_value = 0;

  function automatic int unsigned sat_len(logic [5:0] v);
    return (v > NBYTES) ? NBYTES : v;
  endfunction

  // left-to-right square and multiply on wide vectors
  function automatic logic [511:0] modexp_value(output int unsigned ln);
    logic [511:0] mv, bv, acc;
    int unsigned lb, le;
    bit nz, started;
    ln = sat_len(mod_len_q);
    lb = sat_len(base_len_q);
    le = sat_len(exp_len_q);
    mv = '0;
    bv = '0;
    for (int i = 0; i < ln; i++) mv[8*i +: 8] = mod_digits[i];
    for (int i = 0; i < lb; i++) bv[8*i +: 8] = base_digits[i];
    nz = (mv != 0);
    acc = 512'd1;
    started = 0;
    for (int i = le - 1; i >= 0; i--) begin
      for (int b = 7; b >= 0; b--) begin
        if (started && nz) acc = (acc * acc) % mv;
        if (exp_digits[i][b]) begin
          acc = nz ? (acc * bv) % mv : '0;
          started = 1;
        end
      end
    end
    return acc;
  endfunction

  task automatic push_remainder(logic [511:0] acc, int unsigned ln);
    res_byte_t r;
    int unsigned sig;
    sig = 0;
    for (int k = 0; k < ln; k++) if (acc[8*k +: 8] != 0) sig = k + 1;
    for (int k = 0; k < ln; k++) begin
      r.index = k[4:0];
      r.value = acc[8*k +: 8];
      r.length = sig[5:0];
      r.last = (k == ln - 1);
      remainder_q.push_back(r);
    end
  endtask

  // request side: mirror loads, predict starts
  always @(posedge clk_i) begin
    logic [511:0] acc;
    int unsigned ln;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      case (s_axis_tuser_i)
        mexp_pkg::CMD_LOAD_MOD:  mod_digits[s_axis_tdata_i[4:0]] = s_axis_tdata_i[12:5];
        mexp_pkg::CMD_LOAD_BASE: base_digits[s_axis_tdata_i[4:0]] = s_axis_tdata_i[12:5];
        mexp_pkg::CMD_LOAD_EXP:  exp_digits[s_axis_tdata_i[4:0]] = s_axis_tdata_i[12:5];
        default: begin
          acc = modexp_value(ln);
          if (typed_pending) begin
            if (acc != typed_value) begin
              $error("typed remainder differs from prediction: %0h vs %0h",
                     typed_value, acc);
              failures++;
            end
            acc = 512'(typed_value);
            typed_pending = 0;
          end
          push_remainder(acc, ln);
        end
      endcase
    end
  end

  // result side: compare against oldest expectation
  always @(posedge clk_i) begin
    res_byte_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      bytes_seen++;
      if (remainder_q.size() == 0) begin
        $error("result byte with nothing expected: %h", m_axis_tdata_o);
        failures++;
      end else begin
        e = remainder_q.pop_front();
        if (m_axis_tdata_o[4:0] !== e.index) begin
          $error("result_index expected %0d actual %0d", e.index, m_axis_tdata_o[4:0]);
          failures++;
        end
        if (m_axis_tdata_o[12:5] !== e.value) begin
          $error("result_byte expected %0h actual %0h", e.value, m_axis_tdata_o[12:5]);
          failures++;
        end
        if (m_axis_tdata_o[18:13] !== e.length) begin
          $error("result_length expected %0d actual %0d", e.length,
                 m_axis_tdata_o[18:13]);
          failures++;
        end
        if (m_axis_tlast_o !== e.last) begin
          $error("last expected %0b actual %0b", e.last, m_axis_tlast_o);
          failures++;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) < stall_pct) ? 1'b0 : 1'b1;
  end

  task automatic send_request(logic [1:0] cmd, int idx, int val);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= cmd;
    s_axis_tdata_i <= {3'b000, 8'(val), 5'(idx)};
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    if (cmd == mexp_pkg::CMD_START) starts_sent++;
  endtask

  // wait for every expected byte, then for any result-free start to finish
  task automatic drain_block();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (remainder_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] reg_idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {reg_idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_idx)
      mexp_pkg::REG_MOD_LEN:  mod_len_q = val[5:0];
      mexp_pkg::REG_BASE_LEN: base_len_q = val[5:0];
      mexp_pkg::REG_EXP_LEN:  exp_len_q = val[5:0];
      default: ;
    endcase
  endtask

  task automatic set_lengths(int m, int b, int e);
    drain_block();
    apb_write(mexp_pkg::REG_MOD_LEN, m);
    apb_write(mexp_pkg::REG_BASE_LEN, b);
    apb_write(mexp_pkg::REG_EXP_LEN, e);
  endtask

  task automatic start_typed(int known);
    typed_pending = 1;
    typed_value = known;
    send_request(mexp_pkg::CMD_START, 0, $urandom_range(255));
  endtask

  // directed rows, run with 2-byte modulus and base, 1-byte exponent
  dir_row_t dir_rows[22] = '{
    '{mexp_pkg::CMD_LOAD_MOD,  5'd0, 8'hff, 0, 0},
    '{mexp_pkg::CMD_LOAD_MOD,  5'd1, 8'hff, 0, 0},
    '{mexp_pkg::CMD_LOAD_BASE, 5'd0, 8'hff, 0, 0},
    '{mexp_pkg::CMD_LOAD_BASE, 5'd1, 8'hff, 0, 0},
    '{mexp_pkg::CMD_LOAD_EXP,  5'd0, 8'h00, 0, 0},
    '{mexp_pkg::CMD_START,     5'd0, 8'h00, 1, 1},
    '{mexp_pkg::CMD_LOAD_EXP,  5'd0, 8'hff, 0, 0},
    '{mexp_pkg::CMD_START,     5'd0, 8'h00, 0, 0},
    '{mexp_pkg::CMD_LOAD_EXP,  5'd0, 8'h01, 0, 0},
    '{mexp_pkg::CMD_START,     5'd0, 8'h00, 1, 0},
    '{mexp_pkg::CMD_LOAD_BASE, 5'd0, 8'h00, 0, 0},
    '{mexp_pkg::CMD_LOAD_BASE, 5'd1, 8'h00, 0, 0},
    '{mexp_pkg::CMD_LOAD_EXP,  5'd0, 8'h80, 0, 0},
    '{mexp_pkg::CMD_START,     5'd0, 8'h00, 1, 0},
    '{mexp_pkg::CMD_LOAD_BASE, 5'd0, 8'h80, 0, 0},
    '{mexp_pkg::CMD_LOAD_BASE, 5'd1, 8'h01, 0, 0},
    '{mexp_pkg::CMD_LOAD_MOD,  5'd0, 8'h00, 0, 0},
    '{mexp_pkg::CMD_LOAD_MOD,  5'd1, 8'h00, 0, 0},
    '{mexp_pkg::CMD_START,     5'd0, 8'h00, 1, 0},
    '{mexp_pkg::CMD_LOAD_MOD,  5'd0, 8'h01, 0, 0},
    '{mexp_pkg::CMD_LOAD_MOD,  5'd1, 8'h80, 0, 0},
    '{mexp_pkg::CMD_START,     5'd0, 8'h00, 0, 0}
  };

  initial begin
    int m, b, e, nloads;
    logic [1:0] c;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every store entry gets a defined value before any start
    apb_write(mexp_pkg::REG_MOD_LEN, 2);
    apb_write(mexp_pkg::REG_BASE_LEN, 2);
    apb_write(mexp_pkg::REG_EXP_LEN, 1);
    for (int i = 0; i < NBYTES; i++) begin
      send_request(mexp_pkg::CMD_LOAD_MOD, i, $urandom_range(255));
      send_request(mexp_pkg::CMD_LOAD_BASE, i, $urandom_range(255));
      send_request(mexp_pkg::CMD_LOAD_EXP, i, 0);
    end

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cmd == mexp_pkg::CMD_START && dir_rows[i].typed)
        start_typed(dir_rows[i].known);
      else
        send_request(dir_rows[i].cmd, int'(dir_rows[i].index), int'(dir_rows[i].value));
    end

    // zero exponent by length, with a zero base: still one
    set_lengths(2, 0, 0);
    start_typed(1);
    // zero base with a nonzero exponent
    set_lengths(2, 0, 1);
    start_typed(0);
    // single-byte modulus, and no modulus at all
    set_lengths(1, 2, 1);
    send_request(mexp_pkg::CMD_START, 0, 0);
    set_lengths(0, 2, 1);
    send_request(mexp_pkg::CMD_START, 0, 0);
    // widest modulus and base, two-product exponent
    set_lengths(32, 32, 1);
    send_request(mexp_pkg::CMD_LOAD_MOD, 31, 8'hff);
    send_request(mexp_pkg::CMD_LOAD_EXP, 0, 8'h02);
    send_request(mexp_pkg::CMD_START, 0, 0);
    // saturating base length and full-width exponent scan
    set_lengths(2, 63, 32);
    send_request(mexp_pkg::CMD_START, 0, 0);
    send_request(mexp_pkg::CMD_LOAD_EXP, 0, 8'h00);

    // random phases over the idling modes
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 67 : 19) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 67 : 19) : 0;
      for (int s = 0; s < 7; s++) begin
        if (s % 3 == 0) begin
          m = $urandom_range(4, 1);
          b = $urandom_range(m + 1, 0);
          e = $urandom_range(2, 1);
          if ($urandom_range(9) == 0) e = 0;
          set_lengths(m, b, e);
          if (m > 1) send_request(mexp_pkg::CMD_LOAD_EXP, 1, 8'h00);
        end
        if (ph == 2 && s == 4) drain_block();
        nloads = $urandom_range(7, 4);
        for (int k = 0; k < nloads; k++) begin
          c = 2'($urandom_range(2));
          // exponent stays low to keep starts short
          if (c == mexp_pkg::CMD_LOAD_EXP)
            send_request(c, 0, $urandom_range(255));
          else if ($urandom_range(4) == 0)
            send_request(c, $urandom_range(31), $urandom_range(255));
          else
            send_request(c, $urandom_range(m - 1), $urandom_range(255));
        end
        // keep the top modulus byte nonzero most of the time
        if ($urandom_range(3) != 0)
          send_request(mexp_pkg::CMD_LOAD_MOD, m - 1, $urandom_range(255, 1));
        send_request(mexp_pkg::CMD_START, 0, 0);
      end
    end

    drain_block();
    $display("covered %0d requests, %0d starts, %0d result bytes checked",
             items_sent, starts_sent, bytes_seen);
    $display("lengths from zero to full width, all four idling modes");
    if (failures == 0 && remainder_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
